/* rtl/srce_pkg.sv */
// shared types, command and opcode codes, and immediate helpers for the small risc core
// no dependencies; used by srce_regfile and small_risc_core_execute
package srce_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [6:0] OP_ECALL = 7'd1;
    localparam logic [6:0] OP_ADD   = 7'd2;
    localparam logic [6:0] OP_ADDI  = 7'd3;
    localparam logic [6:0] OP_BEQ   = 7'd4;
    localparam logic [6:0] OP_BLTU  = 7'd5;
    localparam logic [6:0] OP_CALL  = 7'd6;
    localparam logic [6:0] OP_RET   = 7'd7;
    localparam logic [6:0] OP_J     = 7'd8;
    localparam logic [6:0] OP_LI    = 7'd9;
    localparam logic [6:0] OP_LUI   = 7'd10;
    localparam logic [6:0] OP_MV    = 7'd11;
    localparam logic [6:0] OP_LW    = 7'd12;
    localparam logic [6:0] OP_SW    = 7'd13;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_LINK = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;
    localparam logic [4:0] REG_ARG0 = 5'd10;
    localparam logic [4:0] REG_ARG1 = 5'd11;

    typedef struct packed {
        logic       en;
        logic [4:0] a_addr;
        logic [4:0] b_addr;
    } rf_rd_t;

    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

    function automatic logic [31:0] sext12(input logic [31:0] ins);
        return {{20{ins[31]}}, ins[31:20]};
    endfunction

    function automatic logic [31:0] sext20(input logic [31:0] ins);
        return {{12{ins[31]}}, ins[31:12]};
    endfunction

endpackage

/* rtl/srce_mem.sv */
// single port synchronous word memory; read data is registered and appears the cycle after the request
// no package dependencies; instantiated by small_risc_core_execute
module srce_mem #(
    parameter int MEM_WORDS = 1024,
    parameter int AW        = 10
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] ram [MEM_WORDS];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                ram[addr] <= wdata;
            end else begin
                rdata <= ram[addr];
            end
        end
    end

endmodule

/* rtl/srce_regfile.sv */
// 32 x 32 register file memory, two registered read ports and one write port
// per-entry valid bits give the reset contents; depends on srce_pkg
module srce_regfile #(
    parameter int MEM_WORDS = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  srce_pkg::rf_rd_t rd_req,
    input  srce_pkg::rf_wr_t wr_req,
    output logic [31:0]      a_data,
    output logic [31:0]      b_data
);

    localparam logic [31:0] SP_RESET = 32'(MEM_WORDS * 4);

    logic [31:0] ram [32];
    logic [31:0] valid_reg;

    function automatic logic [31:0] reset_val(input logic [4:0] idx);
        return (idx == srce_pkg::REG_SP) ? SP_RESET : 32'd0;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_req.we && wr_req.addr != srce_pkg::REG_ZERO) begin
            valid_reg[wr_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_req.we && wr_req.addr != srce_pkg::REG_ZERO) begin
            ram[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en) begin
            a_data <= valid_reg[rd_req.a_addr] ? ram[rd_req.a_addr] : reset_val(rd_req.a_addr);
            b_data <= valid_reg[rd_req.b_addr] ? ram[rd_req.b_addr] : reset_val(rd_req.b_addr);
        end
    end

endmodule

/* rtl/srce_wrap.sv */
// reduces a 30-bit word index modulo the memory depth
// in range it is registered directly, else reduced by reciprocal multiply; no package use
module srce_wrap #(
    parameter int MEM_WORDS = 1024,
    parameter int AW        = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [29:0]   x,
    output logic          done,
    output logic [AW-1:0] r
);

    localparam int RECIP = (2 ** 30) / MEM_WORDS;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = 30 + RW;
    localparam int MBW   = AW + 1;
    localparam int QMW   = RW + MBW;
    localparam logic [29:0] DEPTH = 30'(MEM_WORDS);

    logic          s1_reg;
    logic          s2_reg;
    logic          done_reg;
    logic [29:0]   x_reg;
    logic [PW-1:0] prod_reg;
    logic [29:0]   qm_reg;
    logic [AW-1:0] r_reg;
    logic [QMW-1:0] qm_full;
    logic [29:0]   diff;
    logic [29:0]   fixed;

    assign qm_full = QMW'(prod_reg[PW-1:30]) * QMW'(MEM_WORDS);
    assign diff    = x_reg - qm_reg;
    assign fixed   = (diff >= DEPTH) ? diff - DEPTH : diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            s1_reg   <= start && (x >= DEPTH);
            s2_reg   <= s1_reg;
            done_reg <= (start && (x < DEPTH)) || s2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= x;
            prod_reg <= PW'(x) * PW'(RECIP);
            if (x < DEPTH) begin
                r_reg <= x[AW-1:0];
            end
        end
        if (s1_reg) begin
            qm_reg <= qm_full[29:0];
        end
        if (s2_reg) begin
            r_reg <= fixed[AW-1:0];
        end
    end

    assign done = done_reg;
    assign r    = r_reg;

endmodule

/* rtl/small_risc_core_execute.sv */
// small risc core: sequencer around one word memory and a register file memory
// per item: write/read wrap the word index, then access memory; step wraps the pc, fetches and
// executes (only reports when halted); lw/sw also wrap the address and access one word, two if
// unaligned; all use the single memory port; one item waits in the input register meanwhile
// reset: synchronous active low, then a clearing pass over all MEM_WORDS words with s_ready low
// depends on srce_pkg, srce_mem, srce_regfile, srce_wrap
module small_risc_core_execute #(
    parameter int MEM_WORDS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [9:0]  s_word_index,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_executed_pc,
    output logic        m_ecall_seen,
    output logic [31:0] m_ecall_arg0,
    output logic [31:0] m_ecall_arg1,
    output logic        m_halted,
    output logic [31:0] m_read_data
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_IDX   = 4'd2;
    localparam logic [3:0] S_RDATA = 4'd3;
    localparam logic [3:0] S_FMOD  = 4'd4;
    localparam logic [3:0] S_FETCH = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_AMOD  = 4'd7;
    localparam logic [3:0] S_LO    = 4'd8;
    localparam logic [3:0] S_HI    = 4'd9;
    localparam logic [3:0] S_STHI  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic          buf_valid_reg, buf_valid_next;
    logic [1:0]    buf_cmd_reg;
    logic [9:0]    buf_idx_reg;
    logic [31:0]   buf_wdata_reg;
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [31:0]   wdata_reg, wdata_next;
    logic [31:0]   pc_reg, pc_next;
    logic          stopped_reg, stopped_next;
    logic [31:0]   ins_reg, ins_next;
    logic [1:0]    off_reg, off_next;
    logic [AW-1:0] w0_reg, w0_next;
    logic [AW-1:0] w1_reg, w1_next;
    logic [31:0]   lo_reg, lo_next;
    logic [31:0]   hi_reg, hi_next;
    logic [31:0]   res_pc_reg, res_pc_next;
    logic          res_ecall_reg, res_ecall_next;
    logic [31:0]   res_arg0_reg, res_arg0_next;
    logic [31:0]   res_arg1_reg, res_arg1_next;
    logic [31:0]   res_rdata_reg, res_rdata_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_pc_reg, out_pc_next;
    logic          out_ecall_reg, out_ecall_next;
    logic [31:0]   out_arg0_reg, out_arg0_next;
    logic [31:0]   out_arg1_reg, out_arg1_next;
    logic          out_halted_reg, out_halted_next;
    logic [31:0]   out_rdata_reg, out_rdata_next;

    logic          take;
    logic          mem_en, mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata, mem_rdata;
    logic          mod_start, mod_done;
    logic [29:0]   mod_x;
    logic [AW-1:0] mod_r;
    srce_pkg::rf_rd_t rf_rd;
    srce_pkg::rf_wr_t rf_wr;
    logic [31:0]   rf_a, rf_b;

    logic [6:0]    f_op;
    logic [6:0]    ins_op;
    logic [4:0]    ins_rd;
    logic [31:0]   imm_val, jmp_off, pc_plus4, br_tgt, jmp_tgt, eff_addr;
    logic [4:0]    sh;
    logic [63:0]   pair, mask, ins_bits, new_pair, load_pair;

    assign f_op     = mem_rdata[6:0];
    assign ins_op   = ins_reg[6:0];
    assign ins_rd   = ins_reg[11:7];
    assign imm_val  = srce_pkg::sext12(ins_reg);
    assign jmp_off  = srce_pkg::sext20(ins_reg);
    assign pc_plus4 = pc_reg + 32'd4;
    assign br_tgt   = pc_reg + {imm_val[30:0], 1'b0};
    assign jmp_tgt  = pc_reg + {jmp_off[30:0], 1'b0};
    assign eff_addr = rf_a + imm_val;
    assign sh       = {off_reg, 3'b000};
    assign pair     = {mem_rdata, lo_reg};
    assign mask     = 64'h0000_0000_ffff_ffff << sh;
    assign ins_bits = {32'd0, wdata_reg} << sh;
    assign new_pair = (pair & ~mask) | ins_bits;
    assign load_pair = pair >> sh;

    assign s_ready = !buf_valid_reg && (state_reg != S_CLEAR);
    assign buf_valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : buf_valid_reg);

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cmd_next        = cmd_reg;
        wdata_next      = wdata_reg;
        pc_next         = pc_reg;
        stopped_next    = stopped_reg;
        ins_next        = ins_reg;
        off_next        = off_reg;
        w0_next         = w0_reg;
        w1_next         = w1_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_pc_next     = res_pc_reg;
        res_ecall_next  = res_ecall_reg;
        res_arg0_next   = res_arg0_reg;
        res_arg1_next   = res_arg1_reg;
        res_rdata_next  = res_rdata_reg;
        out_valid_next  = (out_valid_reg && m_ready) ? 1'b0 : out_valid_reg;
        out_pc_next     = out_pc_reg;
        out_ecall_next  = out_ecall_reg;
        out_arg0_next   = out_arg0_reg;
        out_arg1_next   = out_arg1_reg;
        out_halted_next = out_halted_reg;
        out_rdata_next  = out_rdata_reg;
        take      = 1'b0;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = w0_reg;
        mem_wdata = 32'd0;
        mod_start = 1'b0;
        mod_x     = 30'd0;
        rf_rd     = '0;
        rf_wr     = '0;

        case (state_reg)
            S_CLEAR: begin
                mem_en       = 1'b1;
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (buf_valid_reg) begin
                    take           = 1'b1;
                    cmd_next       = buf_cmd_reg;
                    wdata_next     = buf_wdata_reg;
                    res_pc_next    = 32'd0;
                    res_ecall_next = 1'b0;
                    res_arg0_next  = 32'd0;
                    res_arg1_next  = 32'd0;
                    res_rdata_next = 32'd0;
                    state_next     = S_DONE;
                    case (buf_cmd_reg)
                        srce_pkg::CMD_WRITE, srce_pkg::CMD_READ: begin
                            mod_start  = 1'b1;
                            mod_x      = 30'(buf_idx_reg);
                            state_next = S_IDX;
                        end
                        srce_pkg::CMD_STEP: begin
                            if (!stopped_reg) begin
                                mod_start  = 1'b1;
                                mod_x      = pc_reg[31:2];
                                state_next = S_FMOD;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_IDX: begin
                if (mod_done) begin
                    mem_en   = 1'b1;
                    mem_addr = mod_r;
                    if (cmd_reg == srce_pkg::CMD_WRITE) begin
                        mem_we     = 1'b1;
                        mem_wdata  = wdata_reg;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_RDATA;
                    end
                end
            end
            S_RDATA: begin
                res_rdata_next = mem_rdata;
                state_next     = S_DONE;
            end
            S_FMOD: begin
                if (mod_done) begin
                    mem_en     = 1'b1;
                    mem_addr   = mod_r;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                ins_next    = mem_rdata;
                res_pc_next = pc_reg;
                rf_rd.en    = 1'b1;
                if (f_op == srce_pkg::OP_ECALL) begin
                    rf_rd.a_addr = srce_pkg::REG_ARG0;
                    rf_rd.b_addr = srce_pkg::REG_ARG1;
                end else begin
                    rf_rd.a_addr = (f_op == srce_pkg::OP_RET) ? srce_pkg::REG_LINK
                                                              : mem_rdata[16:12];
                    rf_rd.b_addr = (f_op == srce_pkg::OP_ADD) ? mem_rdata[21:17]
                                                              : mem_rdata[11:7];
                end
                state_next = S_EXEC;
            end
            S_EXEC: begin
                pc_next    = pc_plus4;
                state_next = S_DONE;
                rf_wr.addr = ins_rd;
                case (ins_op)
                    srce_pkg::OP_ECALL: begin
                        res_ecall_next = 1'b1;
                        res_arg0_next  = rf_a;
                        res_arg1_next  = rf_b;
                    end
                    srce_pkg::OP_ADD: begin
                        rf_wr.we   = 1'b1;
                        rf_wr.data = rf_a + rf_b;
                    end
                    srce_pkg::OP_ADDI: begin
                        rf_wr.we   = 1'b1;
                        rf_wr.data = eff_addr;
                    end
                    srce_pkg::OP_BEQ: begin
                        pc_next = (rf_b == rf_a) ? br_tgt : pc_plus4;
                    end
                    srce_pkg::OP_BLTU: begin
                        pc_next = (rf_b < rf_a) ? br_tgt : pc_plus4;
                    end
                    srce_pkg::OP_CALL: begin
                        rf_wr.we   = 1'b1;
                        rf_wr.addr = srce_pkg::REG_LINK;
                        rf_wr.data = pc_plus4;
                        pc_next    = jmp_tgt;
                    end
                    srce_pkg::OP_RET: begin
                        pc_next = rf_a;
                    end
                    srce_pkg::OP_J: begin
                        pc_next = jmp_tgt;
                    end
                    srce_pkg::OP_LI: begin
                        rf_wr.we   = 1'b1;
                        rf_wr.data = imm_val;
                    end
                    srce_pkg::OP_LUI: begin
                        rf_wr.we   = 1'b1;
                        rf_wr.data = {ins_reg[31:12], 12'd0};
                    end
                    srce_pkg::OP_MV: begin
                        rf_wr.we   = 1'b1;
                        rf_wr.data = rf_a;
                    end
                    srce_pkg::OP_LW, srce_pkg::OP_SW: begin
                        mod_start  = 1'b1;
                        mod_x      = eff_addr[31:2];
                        off_next   = eff_addr[1:0];
                        wdata_next = rf_b;
                        state_next = S_AMOD;
                    end
                    default: begin
                        stopped_next = 1'b1;
                        pc_next      = pc_reg;
                    end
                endcase
            end
            S_AMOD: begin
                if (mod_done) begin
                    w0_next    = mod_r;
                    w1_next    = (mod_r == LAST_IDX || &eff_addr[31:2]) ? '0
                                                                        : mod_r + AW'(1);
                    mem_en     = 1'b1;
                    mem_addr   = mod_r;
                    state_next = S_LO;
                end
            end
            S_LO: begin
                lo_next = mem_rdata;
                if (off_reg == 2'd0) begin
                    state_next = S_DONE;
                    if (ins_op == srce_pkg::OP_LW) begin
                        rf_wr.we   = 1'b1;
                        rf_wr.addr = ins_rd;
                        rf_wr.data = mem_rdata;
                    end else begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = w0_reg;
                        mem_wdata = wdata_reg;
                    end
                end else begin
                    mem_en     = 1'b1;
                    mem_addr   = w1_reg;
                    state_next = S_HI;
                end
            end
            S_HI: begin
                if (ins_op == srce_pkg::OP_LW) begin
                    rf_wr.we   = 1'b1;
                    rf_wr.addr = ins_rd;
                    rf_wr.data = load_pair[31:0];
                    state_next = S_DONE;
                end else begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    mem_addr   = w0_reg;
                    mem_wdata  = new_pair[31:0];
                    hi_next    = new_pair[63:32];
                    state_next = S_STHI;
                end
            end
            S_STHI: begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = w1_reg;
                mem_wdata  = hi_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_pc_next     = res_pc_reg;
                    out_ecall_next  = res_ecall_reg;
                    out_arg0_next   = res_arg0_reg;
                    out_arg1_next   = res_arg1_reg;
                    out_halted_next = stopped_reg;
                    out_rdata_next  = res_rdata_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            pc_reg        <= 32'd0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            buf_valid_reg <= buf_valid_next;
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pc_reg        <= pc_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            buf_cmd_reg   <= s_cmd;
            buf_idx_reg   <= s_word_index;
            buf_wdata_reg <= s_write_data;
        end
        cmd_reg        <= cmd_next;
        wdata_reg      <= wdata_next;
        ins_reg        <= ins_next;
        off_reg        <= off_next;
        w0_reg         <= w0_next;
        w1_reg         <= w1_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_pc_reg     <= res_pc_next;
        res_ecall_reg  <= res_ecall_next;
        res_arg0_reg   <= res_arg0_next;
        res_arg1_reg   <= res_arg1_next;
        res_rdata_reg  <= res_rdata_next;
        out_pc_reg     <= out_pc_next;
        out_ecall_reg  <= out_ecall_next;
        out_arg0_reg   <= out_arg0_next;
        out_arg1_reg   <= out_arg1_next;
        out_halted_reg <= out_halted_next;
        out_rdata_reg  <= out_rdata_next;
    end

    srce_mem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    srce_regfile #(
        .MEM_WORDS (MEM_WORDS)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rf_rd),
        .wr_req  (rf_wr),
        .a_data  (rf_a),
        .b_data  (rf_b)
    );

    srce_wrap #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_wrap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .x       (mod_x),
        .done    (mod_done),
        .r       (mod_r)
    );

    assign m_valid       = out_valid_reg;
    assign m_executed_pc = out_pc_reg;
    assign m_ecall_seen  = out_ecall_reg;
    assign m_ecall_arg0  = out_arg0_reg;
    assign m_ecall_arg1  = out_arg1_reg;
    assign m_halted      = out_halted_reg;
    assign m_read_data   = out_rdata_reg;

endmodule

/* rtl/srce_checker.sv */
// port-level assertions for small_risc_core_execute, attached with bind
// sees only the top level ports; no package dependencies
module srce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_executed_pc,
    input logic        m_ecall_seen,
    input logic [31:0] m_ecall_arg0,
    input logic [31:0] m_ecall_arg1,
    input logic        m_halted
);

    // results disappear and the memory clearing pass starts on reset
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready during clearing pass");

    // an ecall only runs on a core that has not stopped
    a_ecall_live: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ecall_seen |-> !m_halted)
        else $error("ecall reported on a halted core");

    a_args_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ecall_seen |-> (m_ecall_arg0 == 32'd0) && (m_ecall_arg1 == 32'd0))
        else $error("ecall arguments without ecall");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_executed_pc))
        else $error("stalled transfer changed");

endmodule

bind small_risc_core_execute srce_checker u_srce_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_executed_pc (m_executed_pc),
    .m_ecall_seen  (m_ecall_seen),
    .m_ecall_arg0  (m_ecall_arg0),
    .m_ecall_arg1  (m_ecall_arg1),
    .m_halted      (m_halted)
);
